>>> hdl/vdn_pkg.sv
// shared types and constants for the dot product and norm core
package vdn_pkg;

   localparam int ElemBits    = 16;
   localparam int DotBits     = 42;
   localparam int SqBits      = 41;
   localparam int AbsBits     = 26;
   localparam int PeakBits    = 16;
   localparam int RootBits    = 21;
   localparam int QueueDepth  = 4;
   localparam int QueueIdx    = 2;

   localparam logic signed [DotBits-1:0] DotHi = 42'sd1099511627775;
   localparam logic signed [DotBits-1:0] DotLo = -42'sd1099511627776;
   localparam logic [SqBits-1:0]  SqCap  = 41'd1 << 40;
   localparam logic [AbsBits-1:0] AbsCap = 26'd1 << 25;

   // accumulated sums for one finished vector pair
   typedef struct packed {
      logic signed [DotBits-1:0] dot;
      logic [SqBits-1:0]         sq_u;
      logic [SqBits-1:0]         sq_v;
      logic [AbsBits-1:0]        abs_u;
      logic [AbsBits-1:0]        abs_v;
      logic [PeakBits-1:0]       peak_u;
      logic [PeakBits-1:0]       peak_v;
   } sums_type;

   typedef struct packed {
      logic signed [40:0]  dot_total;
      logic [25:0]         norm_one_u;
      logic [25:0]         norm_one_v;
      logic [20:0]         norm_two_u;
      logic [20:0]         norm_two_v;
      logic [15:0]         norm_max_u;
      logic [15:0]         norm_max_v;
      logic signed [15:0]  cos_angle;
      logic                cos_valid;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] u_elem;
      logic signed [15:0] v_elem;
      logic               last_elem;
   } req_type;

endpackage

>>> hdl/vdn_if.sv
// valid/ready channel carrying one payload struct
interface vdn_req_if (input logic clock);
   import vdn_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface vdn_rsp_if (input logic clock);
   import vdn_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> hdl/vdn_accum.sv
// front part: per-beat saturating accumulation of the element pairs
module vdn_accum (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  vdn_pkg::req_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output vdn_pkg::sums_type out_data
);
   import vdn_pkg::*;

   logic               valid_ff, valid_in;
   sums_type           acc_ff, acc_in, res_ff, res_in;
   logic               take;
   logic [15:0]        au, av;
   logic [31:0]        pm, squ, sqv;
   logic signed [DotBits:0] dsum;
   logic [SqBits:0]    su, sv;
   logic [AbsBits:0]   bu, bv;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_data  = res_ff;

   always_comb begin
      au  = in_data.u_elem[15] ? 16'(-in_data.u_elem) : 16'(in_data.u_elem);
      av  = in_data.v_elem[15] ? 16'(-in_data.v_elem) : 16'(in_data.v_elem);
      pm  = au * av;
      squ = au * au;
      sqv = av * av;
      if (in_data.u_elem[15] != in_data.v_elem[15])
         dsum = 43'(acc_ff.dot) - 43'(pm);
      else
         dsum = 43'(acc_ff.dot) + 43'(pm);
      su = 42'(acc_ff.sq_u) + 42'(squ);
      sv = 42'(acc_ff.sq_v) + 42'(sqv);
      bu = 27'(acc_ff.abs_u) + 27'(au);
      bv = 27'(acc_ff.abs_v) + 27'(av);
      acc_in.dot    = dsum > 43'(DotHi) ? DotHi
                    : (dsum < 43'(DotLo) ? DotLo : DotBits'(dsum));
      acc_in.sq_u   = su > 42'(SqCap) ? SqCap : SqBits'(su);
      acc_in.sq_v   = sv > 42'(SqCap) ? SqCap : SqBits'(sv);
      acc_in.abs_u  = bu > 27'(AbsCap) ? AbsCap : AbsBits'(bu);
      acc_in.abs_v  = bv > 27'(AbsCap) ? AbsCap : AbsBits'(bv);
      acc_in.peak_u = au > acc_ff.peak_u ? au : acc_ff.peak_u;
      acc_in.peak_v = av > acc_ff.peak_v ? av : acc_ff.peak_v;
      res_in   = res_ff;
      valid_in = valid_ff && !out_ready;
      if (take && in_data.last_elem) begin
         res_in   = acc_in;
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
      if (reset) begin
         valid_ff <= 1'b0;
         acc_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         if (take)
            acc_ff <= in_data.last_elem ? sums_type'('0) : acc_in;
      end
   end
endmodule

>>> hdl/vdn_queue.sv
// short fifo between the accumulator and the finishing unit
module vdn_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  vdn_pkg::sums_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output vdn_pkg::sums_type out_data
);
   import vdn_pkg::*;

   sums_type            mem [QueueDepth];
   logic [QueueIdx-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QueueIdx:0]   cnt_ff, cnt_in;
   logic                push, pop;

   assign in_ready  = cnt_ff != QueueIdx'(0) + (QueueIdx+1)'(QueueDepth);
   assign out_valid = cnt_ff != '0;
   assign out_data  = mem[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (QueueIdx+1)'(push) - (QueueIdx+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push)
         mem[wr_ff] <= in_data;
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

>>> hdl/vdn_finish.sv
// back part: two square roots, norm product and cosine division, bit serial
module vdn_finish (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  vdn_pkg::sums_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output vdn_pkg::rsp_type  out_data
);
   import vdn_pkg::*;

   typedef enum logic [2:0] {
      IDLE, SQRT, MUL, DIV, DONE
   } state_type;

   state_type        state_ff, state_in;
   sums_type         sums_ff, sums_in;
   logic [5:0]       step_ff, step_in;
   // sqrt working regs for u and v
   logic [41:0]      remu_ff, remu_in, remv_ff, remv_in;
   logic [20:0]      rootu_ff, rootu_in, rootv_ff, rootv_in;
   // sums of squares widened to an even bit count, shifted two bits per step
   logic [41:0]      shu_ff, shu_in, shv_ff, shv_in;
   logic [41:0]      prodn_ff, prodn_in;
   logic [56:0]      num_ff, num_in;
   logic [42:0]      drem_ff, drem_in;
   logic [16:0]      quo_ff, quo_in;
   rsp_type          rsp_ff, rsp_in;
   logic [41:0]      tu, tv;
   logic [42:0]      dtry;
   logic [41:0]      mag;
   logic             valid;
   logic [16:0]      q;

   assign in_ready  = state_ff == IDLE;
   assign out_valid = state_ff == DONE;
   assign out_data  = rsp_ff;

   always_comb begin
      state_in = state_ff;
      sums_in  = sums_ff;
      step_in  = step_ff;
      remu_in  = remu_ff;
      remv_in  = remv_ff;
      rootu_in = rootu_ff;
      rootv_in = rootv_ff;
      shu_in   = shu_ff;
      shv_in   = shv_ff;
      prodn_in = prodn_ff;
      num_in   = num_ff;
      drem_in  = drem_ff;
      quo_in   = quo_ff;
      rsp_in   = rsp_ff;
      mag   = sums_ff.dot[DotBits-1] ? 42'(-sums_ff.dot) : 42'(sums_ff.dot);
      valid = rootu_ff != '0 && rootv_ff != '0;
      // restoring sqrt, one result bit per cycle, 21 steps
      tu   = {remu_ff[39:0], shu_ff[41:40]} - {rootu_ff, 2'b01} ;
      tv   = {remv_ff[39:0], shv_ff[41:40]} - {rootv_ff, 2'b01};
      dtry = {drem_ff[41:0], num_ff[56]} - {1'b0, prodn_ff};
      q    = quo_ff;
      case (state_ff)
         IDLE: begin
            if (in_valid) begin
               sums_in  = in_data;
               shu_in   = {1'b0, in_data.sq_u};
               shv_in   = {1'b0, in_data.sq_v};
               remu_in  = '0;
               remv_in  = '0;
               rootu_in = '0;
               rootv_in = '0;
               step_in  = '0;
               state_in = SQRT;
            end
         end
         SQRT: begin
            if (tu[41]) begin
               remu_in  = {remu_ff[39:0], shu_ff[41:40]};
               rootu_in = {rootu_ff[19:0], 1'b0};
            end else begin
               remu_in  = tu;
               rootu_in = {rootu_ff[19:0], 1'b1};
            end
            if (tv[41]) begin
               remv_in  = {remv_ff[39:0], shv_ff[41:40]};
               rootv_in = {rootv_ff[19:0], 1'b0};
            end else begin
               remv_in  = tv;
               rootv_in = {rootv_ff[19:0], 1'b1};
            end
            shu_in = {shu_ff[39:0], 2'b00};
            shv_in = {shv_ff[39:0], 2'b00};
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd20)
               state_in = MUL;
         end
         MUL: begin
            prodn_in = rootu_ff * rootv_ff;
            num_in   = {mag, 15'd0};
            drem_in  = '0;
            quo_in   = '0;
            step_in  = '0;
            state_in = valid ? DIV : DONE;
            rsp_in.norm_two_u = rootu_ff;
            rsp_in.norm_two_v = rootv_ff;
            rsp_in.dot_total   = 41'(sums_ff.dot);
            rsp_in.norm_one_u  = sums_ff.abs_u;
            rsp_in.norm_one_v  = sums_ff.abs_v;
            rsp_in.norm_max_u  = sums_ff.peak_u;
            rsp_in.norm_max_v  = sums_ff.peak_v;
            rsp_in.cos_angle   = '0;
            rsp_in.cos_valid   = valid;
         end
         DIV: begin
            // restoring divide, 57 quotient bits, saturate once past 17 bits
            if (!dtry[42]) begin
               drem_in = dtry;
               q = {quo_ff[15:0], 1'b1};
            end else begin
               drem_in = {drem_ff[41:0], num_ff[56]};
               q = {quo_ff[15:0], 1'b0};
            end
            if (quo_ff[16])
               q = quo_ff;
            quo_in = q;
            num_in = {num_ff[55:0], 1'b0};
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd56) begin
               if (!sums_ff.dot[DotBits-1])
                  rsp_in.cos_angle = q > 17'd32767 ? 16'sd32767 : 16'(q);
               else
                  rsp_in.cos_angle = q > 17'd32768 ? -16'sd32768 : 16'(-q);
               state_in = DONE;
            end
         end
         DONE: begin
            if (out_ready)
               state_in = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
      end else begin
         state_ff <= state_in;
      end
      sums_ff  <= sums_in;
      step_ff  <= step_in;
      remu_ff  <= remu_in;
      remv_ff  <= remv_in;
      rootu_ff <= rootu_in;
      rootv_ff <= rootv_in;
      shu_ff   <= shu_in;
      shv_ff   <= shv_in;
      prodn_ff <= prodn_in;
      num_ff   <= num_in;
      drem_ff  <= drem_in;
      quo_ff   <= quo_in;
      rsp_ff   <= rsp_in;
   end
endmodule

>>> hdl/vector_dot_norm_cosine_core.sv
// Top level: element pairs in one beat per cycle unless the accumulator is stalled, one result per last beat.
// From last beat to result: queue and register stages, 21 sqrt steps, one multiply,
// 57 divide steps; the divide steps are skipped when a norm is zero.
// Throughput: one element beat per cycle unless held by back-pressure; the finishing
// unit takes new sums only when idle, buffered by a four-entry queue.
// Synchronous active-high reset clears all accumulators and the queue pointers.
module vector_dot_norm_cosine_core (
   input logic clock,
   input logic reset,
   vdn_req_if.sink   req,
   vdn_rsp_if.source rsp
);
   import vdn_pkg::*;

   logic     a_valid, a_ready, f_valid, f_ready;
   sums_type a_data, f_data;

   vdn_accum u_accum (
      .clock, .reset,
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.data),
      .out_valid(a_valid), .out_ready(a_ready), .out_data(a_data)
   );

   vdn_queue u_queue (
      .clock, .reset,
      .in_valid(a_valid), .in_ready(a_ready), .in_data(a_data),
      .out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
   );

   vdn_finish u_finish (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
   );
endmodule

>>> hdl/vdn_checker.sv
// port-level checks for the core, bound to the top level
module vdn_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic cos_valid,
   input logic signed [15:0] cos_angle,
   input logic [20:0] n2u,
   input logic [20:0] n2v
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
   a_cos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !cos_valid |-> cos_angle == 16'sd0) else $error("cos not zero");
   a_cos_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cos_valid == (n2u != 0 && n2v != 0)) else $error("cos flag");
   a_rst: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("rsp after reset");
endmodule

bind vector_dot_norm_cosine_core vdn_checker u_vdn_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .cos_valid(rsp.data.cos_valid), .cos_angle(rsp.data.cos_angle),
   .n2u(rsp.data.norm_two_u), .n2v(rsp.data.norm_two_v)
);
